/* hdl/bpfa_pkg.sv */
`default_nettype none

package bpfa_pkg;

  localparam int unsigned MAX_FRAMES_DEF    = 65536;
  localparam int unsigned MAP_WORD_BITS_DEF = 64;

  localparam int unsigned CFG_W      = 17;
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned TYPE_W     = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned PAGE_ROUND = 4095;
  localparam int unsigned PG_W       = ADDR_W - PAGE_SHIFT;
  localparam int unsigned SPAN_W     = ADDR_W + 1 - PAGE_SHIFT;

  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;
  localparam int unsigned REG_SEL_BIT = 2;

  localparam logic [TYPE_W-1:0] REGION_USABLE = TYPE_W'(1);

  typedef enum logic {
    REG_NFRAMES     = 1'b0,
    REG_FIRST_ALLOC = 1'b1
  } reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_REGION = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_FRAME = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic [6:0] {
    ST_CLR   = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_PREP  = 7'b0000100,
    ST_CLAMP = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_FETCH = 7'b0100000,
    ST_CHK   = 7'b1000000
  } state_e;

endpackage

`default_nettype wire

/* hdl/bpfa_divider.sv */
`default_nettype none

module bpfa_divider #(
  parameter int unsigned DW      = 17,
  parameter int unsigned DIVISOR = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [DW-1:0]                dividend_i,
  output logic                              done_o,
  output logic [DW-1:0]                     quotient_o,
  output logic [$clog2(DIVISOR)-1:0]        remainder_o
);

  localparam int unsigned RW = $clog2(DIVISOR);

  logic [DW-1:0] q_q;
  logic [RW-1:0] r_q;
  logic          done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  // power-of-two divisor: shift and mask, result registered
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i >> RW;
      r_q <= dividend_i[RW-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = q_q;
  assign remainder_o = r_q;

endmodule

`default_nettype wire

/* hdl/bpfa_map_mem.sv */
`default_nettype none

module bpfa_map_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = 10
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/bitmap_page_frame_allocator_core.sv */
// Bitmap allocator of 4 KiB physical frames, first fit; one bit per frame, 1 = free.
// Command channel: an item is taken when start is high and busy is low; mode_i selects
// allocate, free or add memory-map region. One result per item: result_strobe_o is high
// for exactly one cycle with status_o and frame_address_o; the receiver cannot stall.
// Registers for the managed-frame count (0x0) and first_alloc_frame (0x4) sit on the APB
// port, pready always high; write them only while busy is low.
// Flow: the first frame of an item is split into bitmap word index and bit offset by a
// registered shift and mask (word width a power of two). The bitmap RAM then gives one
// word per cycle with a registered read; each word is masked and searched, and written
// back when the item updates it. An item passes ST_PREP, ST_CLAMP (region only), ST_DIV,
// ST_FETCH, then ST_CHK per word: allocate scans to a free frame or the range end, free
// checks one word, region covers its range; rejected or empty items strobe from ST_PREP
// or ST_CLAMP. busy drops with the strobe, so one item is in flight at a time and the next
// may be taken at the edge that ends the strobe cycle. Reset: every frame marked used by a
// clearing pass over all MAP_WORDS words during which busy stays high; both registers reset to zero.
`default_nettype none

module bitmap_page_frame_allocator_core #(
  parameter int unsigned MAX_FRAMES    = bpfa_pkg::MAX_FRAMES_DEF,
  parameter int unsigned MAP_WORD_BITS = bpfa_pkg::MAP_WORD_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [bpfa_pkg::MODE_W-1:0]     mode_i,
  input  wire logic [bpfa_pkg::ADDR_W-1:0]     address_i,
  input  wire logic [bpfa_pkg::ADDR_W-1:0]     region_length_i,
  input  wire logic [bpfa_pkg::TYPE_W-1:0]     region_type_i,
  output logic                                 result_strobe_o,
  output logic [bpfa_pkg::STATUS_W-1:0]        status_o,
  output logic [bpfa_pkg::ADDR_W-1:0]          frame_address_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bpfa_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [bpfa_pkg::PDATA_W-1:0]    pwdata,
  output logic [bpfa_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready
);

  import bpfa_pkg::*;

  localparam int unsigned MAP_WORDS = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned WIW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned FW  = ($clog2(MAX_FRAMES) + 1 > CFG_W) ?
                                ($clog2(MAX_FRAMES) + 1) : CFG_W;
  localparam int unsigned PW  = $clog2(MAP_WORD_BITS);
  localparam logic [WIW-1:0] WORD_LAST = WIW'(MAP_WORDS - 1);
  localparam logic [FW-1:0]  MAX_F     = FW'(MAX_FRAMES);
  localparam logic [FW-1:0]  WBITS     = FW'(MAP_WORD_BITS);

  state_e state_q, state_d;

  logic [CFG_W-1:0]  nframes_q, first_alloc_q;
  logic [MODE_W-1:0] mode_q;
  logic [ADDR_W-1:0] addr_q, len_q;
  logic              usable_q;
  logic [SPAN_W-1:0] first_q, first_d, last_q, last_d;
  logic [FW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [WIW-1:0]    widx_q, widx_d;
  logic [FW-1:0]     base_q, base_d, rem_q, rem_d;
  logic [PW-1:0]     off_q, off_d;
  logic              strobe_q, strobe_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [ADDR_W-1:0] faddr_q, faddr_d;

  logic [FW-1:0]     limit;
  logic              cfg_wr;

  logic              div_start, div_done;
  logic [FW-1:0]     div_quot;
  logic [PW-1:0]     div_rem;

  logic                     mem_we;
  logic [WIW-1:0]           mem_waddr, mem_raddr;
  logic [MAP_WORD_BITS-1:0] mem_wdata, mem_rdata;

  logic [MAP_WORD_BITS-1:0] mask, hit, lowbit;
  logic [PW-1:0]            hit_pos;
  logic                     last_word;
  logic [FW-1:0]            hit_frame;

  logic [PG_W-1:0]   page;
  logic              misaligned;
  logic [ADDR_W:0]   sum_first, sum_last;
  logic [SPAN_W-1:0] fa_w, lim_w, clo, chi;

  assign limit  = (FW'(nframes_q) > MAX_F) ? MAX_F : FW'(nframes_q);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    case (reg_e'(paddr[REG_SEL_BIT]))
      REG_NFRAMES:     prdata = PDATA_W'(nframes_q);
      REG_FIRST_ALLOC: prdata = PDATA_W'(first_alloc_q);
      default:         prdata = '0;
    endcase
  end

  bpfa_divider #(
    .DW      (FW),
    .DIVISOR (MAP_WORD_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (lo_d),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  bpfa_map_mem #(
    .DEPTH (MAP_WORDS),
    .WIDTH (MAP_WORD_BITS),
    .AW    (WIW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // word mask: bits from the first frame offset up to the end of the range
  always_comb begin
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      mask[b] = (PW'(b) >= off_q) && (FW'(b) < rem_q);
    end
  end

  assign hit    = mem_rdata & mask;
  assign lowbit = hit & (~hit + MAP_WORD_BITS'(1));

  always_comb begin
    hit_pos = '0;
    for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
      if (hit[b]) begin
        hit_pos = PW'(b);
      end
    end
  end

  assign last_word = rem_q <= WBITS;
  assign hit_frame = base_q + FW'(hit_pos);

  assign page       = addr_q[ADDR_W-1:PAGE_SHIFT];
  assign misaligned = addr_q[PAGE_SHIFT-1:0] != '0;
  assign sum_first  = {1'b0, addr_q} + (ADDR_W + 1)'(PAGE_ROUND);
  assign sum_last   = {1'b0, addr_q} + {1'b0, len_q};
  assign fa_w       = SPAN_W'(first_alloc_q);
  assign lim_w      = SPAN_W'(limit);
  assign clo        = (first_q < fa_w) ? fa_w : first_q;
  assign chi        = (last_q > lim_w) ? lim_w : last_q;

  always_comb begin
    state_d   = state_q;
    first_d   = first_q;
    last_d    = last_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    widx_d    = widx_q;
    base_d    = base_q;
    rem_d     = rem_q;
    off_d     = off_q;
    strobe_d  = 1'b0;
    status_d  = status_q;
    faddr_d   = faddr_q;
    div_start = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = widx_q;
    mem_wdata = '0;
    mem_raddr = widx_q;

    case (state_q)
      ST_CLR: begin
        mem_we = 1'b1;
        widx_d = widx_q + WIW'(1);
        if (widx_q == WORD_LAST) begin
          widx_d  = '0;
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          state_d = ST_PREP;
        end
      end

      ST_PREP: begin
        status_d = STATUS_OK;
        faddr_d  = '0;
        case (mode_e'(mode_q))
          MODE_ALLOC: begin
            lo_d = FW'(first_alloc_q);
            hi_d = limit;
            if (FW'(first_alloc_q) < limit) begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end else begin
              status_d = STATUS_NO_FRAME;
              strobe_d = 1'b1;
              state_d  = ST_IDLE;
            end
          end
          MODE_FREE: begin
            lo_d = FW'(page);
            hi_d = FW'(page) + FW'(1);
            if (addr_q == '0) begin
              strobe_d = 1'b1;
              state_d  = ST_IDLE;
            end else if (misaligned || page >= PG_W'(limit)) begin
              status_d = STATUS_BAD_FREE;
              strobe_d = 1'b1;
              state_d  = ST_IDLE;
            end else begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
          end
          MODE_REGION: begin
            first_d = sum_first[ADDR_W:PAGE_SHIFT];
            last_d  = sum_last[ADDR_W:PAGE_SHIFT];
            if (usable_q) begin
              state_d = ST_CLAMP;
            end else begin
              strobe_d = 1'b1;
              state_d  = ST_IDLE;
            end
          end
          default: begin
            strobe_d = 1'b1;
            state_d  = ST_IDLE;
          end
        endcase
      end

      ST_CLAMP: begin
        lo_d = FW'(clo);
        hi_d = FW'(chi);
        if (clo < chi) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          strobe_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          widx_d  = div_quot[WIW-1:0];
          base_d  = lo_q - FW'(div_rem);
          off_d   = div_rem;
          state_d = ST_FETCH;
        end
      end

      ST_FETCH: begin
        rem_d   = hi_q - base_q;
        state_d = ST_CHK;
      end

      ST_CHK: begin
        mem_raddr = widx_q + WIW'(1);
        widx_d    = widx_q + WIW'(1);
        base_d    = base_q + WBITS;
        rem_d     = rem_q - WBITS;
        off_d     = '0;
        case (mode_e'(mode_q))
          MODE_ALLOC: begin
            if (hit != '0) begin
              mem_we    = 1'b1;
              mem_wdata = mem_rdata ^ lowbit;
              faddr_d   = ADDR_W'(hit_frame) << PAGE_SHIFT;
              strobe_d  = 1'b1;
              state_d   = ST_IDLE;
            end else if (last_word) begin
              status_d = STATUS_NO_FRAME;
              strobe_d = 1'b1;
              state_d  = ST_IDLE;
            end
          end
          MODE_FREE: begin
            if (hit != '0) begin
              status_d = STATUS_BAD_FREE;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = mem_rdata | mask;
            end
            strobe_d = 1'b1;
            state_d  = ST_IDLE;
          end
          default: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata | mask;
            if (last_word) begin
              strobe_d = 1'b1;
              state_d  = ST_IDLE;
            end
          end
        endcase
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLR;
      widx_q        <= '0;
      strobe_q      <= 1'b0;
      nframes_q     <= '0;
      first_alloc_q <= '0;
    end else begin
      state_q  <= state_d;
      widx_q   <= widx_d;
      strobe_q <= strobe_d;
      if (cfg_wr) begin
        case (reg_e'(paddr[REG_SEL_BIT]))
          REG_NFRAMES:     nframes_q     <= pwdata[CFG_W-1:0];
          REG_FIRST_ALLOC: first_alloc_q <= pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      mode_q   <= mode_i;
      addr_q   <= address_i;
      len_q    <= region_length_i;
      usable_q <= region_type_i == REGION_USABLE;
    end
    first_q  <= first_d;
    last_q   <= last_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    base_q   <= base_d;
    rem_q    <= rem_d;
    off_q    <= off_d;
    status_q <= status_d;
    faddr_q  <= faddr_d;
  end

  assign busy            = state_q != ST_IDLE;
  assign result_strobe_o = strobe_q;
  assign status_o        = status_q;
  assign frame_address_o = faddr_q;

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import bpfa_pkg::*;

  localparam int unsigned FRAMES  = MAX_FRAMES_DEF;
  localparam int          DIR_MAX = 40;

  typedef enum {ROW_CFG, ROW_TYPED, ROW_MODEL} row_kind_e;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [MODE_W-1:0]   mode_i;
  logic [ADDR_W-1:0]   address_i;
  logic [ADDR_W-1:0]   region_length_i;
  logic [TYPE_W-1:0]   region_type_i;
  logic                result_strobe_o;
  logic [STATUS_W-1:0] status_o;
  logic [ADDR_W-1:0]   frame_address_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  bitmap_page_frame_allocator_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .address_i       (address_i),
    .region_length_i (region_length_i),
    .region_type_i   (region_type_i),
    .result_strobe_o (result_strobe_o),
    .status_o        (status_o),
    .frame_address_o (frame_address_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // shadow of the bitmap, 1 = free
  bit                frame_free [FRAMES];
  logic [CFG_W-1:0]  cfg_nframes;
  logic [CFG_W-1:0]  cfg_first_alloc;

  status_e           pend_status [$];
  logic [ADDR_W-1:0] pend_addr [$];
  logic [ADDR_W-1:0] held_frames [$];
  int                errors;

  row_kind_e         dir_kind   [DIR_MAX];
  logic [MODE_W-1:0] dir_mode   [DIR_MAX];
  logic [ADDR_W-1:0] dir_addr   [DIR_MAX];
  logic [ADDR_W-1:0] dir_len    [DIR_MAX];
  logic [TYPE_W-1:0] dir_type   [DIR_MAX];
  status_e           dir_status [DIR_MAX];
  logic [ADDR_W-1:0] dir_frame  [DIR_MAX];
  int                dir_rows;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      if (pend_status.size() == 0) begin
        $display("%0t: unexpected word: status %0d addr %h", $time, status_o, frame_address_o);
        errors++;
      end else begin
        if (status_o !== pend_status[0]) begin
          $display("%0t: status expected %0d got %0d", $time, pend_status[0], status_o);
          errors++;
        end
        if (frame_address_o !== pend_addr[0]) begin
          $display("%0t: frame_address expected %h got %h", $time, pend_addr[0],
                   frame_address_o);
          errors++;
        end
        void'(pend_status.pop_front());
        void'(pend_addr.pop_front());
      end
    end
  end

  function automatic void predict_frame_op(input logic [MODE_W-1:0] mode,
                                           input logic [ADDR_W-1:0] addr,
                                           input logic [ADDR_W-1:0] len,
                                           input logic [TYPE_W-1:0] rtype,
                                           output status_e st,
                                           output logic [ADDR_W-1:0] fa);
    longint unsigned limit, f, lo, hi, a, l;
    bit found;
    limit = (cfg_nframes > FRAMES) ? FRAMES : cfg_nframes;
    a = addr;
    l = len;
    st = STATUS_OK;
    fa = '0;
    found = 1'b0;
    if (mode == MODE_ALLOC) begin
      st = STATUS_NO_FRAME;
      for (f = cfg_first_alloc; f < limit && !found; f++) begin
        if (frame_free[f]) begin
          frame_free[f] = 1'b0;
          found = 1'b1;
          st = STATUS_OK;
          fa = ADDR_W'(f << PAGE_SHIFT);
        end
      end
    end else if (mode == MODE_FREE) begin
      if (a != 0) begin
        f = a >> PAGE_SHIFT;
        if (addr[PAGE_SHIFT-1:0] != 0 || f >= limit || frame_free[f])
          st = STATUS_BAD_FREE;
        else
          frame_free[f] = 1'b1;
      end
    end else if (mode == MODE_REGION && rtype == REGION_USABLE) begin
      lo = (a + PAGE_ROUND) >> PAGE_SHIFT;
      hi = (a + l) >> PAGE_SHIFT;
      if (lo < cfg_first_alloc) lo = cfg_first_alloc;
      if (hi > limit) hi = limit;
      for (f = lo; f < hi; f++) frame_free[f] = 1'b1;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 24);
    return $urandom_range(40, 300);
  endfunction

  task automatic wait_idle();
    bit idle;
    idle = 1'b0;
    while (!idle) begin
      @(negedge clk_i);
      idle = (pend_status.size() == 0) && !busy;
    end
    @(posedge clk_i);
  endtask

  task automatic send_op(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr,
                         input logic [ADDR_W-1:0] len, input logic [TYPE_W-1:0] rtype,
                         input bit typed, input status_e t_st,
                         input logic [ADDR_W-1:0] t_addr);
    status_e st;
    logic [ADDR_W-1:0] fa;
    start <= 1'b1;
    mode_i <= mode;
    address_i <= addr;
    region_length_i <= len;
    region_type_i <= rtype;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_frame_op(mode, addr, len, rtype, st, fa);
    if (mode == MODE_ALLOC && st == STATUS_OK) held_frames.push_back(fa);
    if (typed) begin
      st = t_st;
      fa = t_addr;
    end
    pend_status.push_back(st);
    pend_addr.push_back(fa);
  endtask

  task automatic idle_gap(input bit calm);
    int n;
    n = calm ? 0 : pick_gap();
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic apb_xfer(input bit wr, input logic [PADDR_W-1:0] a,
                          input logic [PDATA_W-1:0] d, output logic [PDATA_W-1:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= a;
    pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    rd = prdata;
    @(posedge clk_i);
  endtask

  task automatic write_config(input logic [CFG_W-1:0] fc, input logic [CFG_W-1:0] first);
    logic [PDATA_W-1:0] rd;
    logic [PDATA_W-CFG_W-1:0] junk;
    @(posedge clk_i);
    start <= 1'b0;
    wait_idle();
    cfg_nframes = fc;
    cfg_first_alloc = first;
    junk = (PDATA_W - CFG_W)'($urandom);
    apb_xfer(1'b1, {REG_NFRAMES, 2'b00}, {junk, fc}, rd);
    junk = (PDATA_W - CFG_W)'($urandom);
    apb_xfer(1'b1, {REG_FIRST_ALLOC, 2'b00}, {junk, first}, rd);
    apb_xfer(1'b0, {REG_NFRAMES, 2'b00}, '0, rd);
    if (rd !== PDATA_W'(fc)) begin
      $display("%0t: nframes read expected %h got %h", $time, PDATA_W'(fc), rd);
      errors++;
    end
    apb_xfer(1'b0, {REG_FIRST_ALLOC, 2'b00}, '0, rd);
    if (rd !== PDATA_W'(first)) begin
      $display("%0t: first_alloc_frame read expected %h got %h", $time, PDATA_W'(first), rd);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic add_row(input row_kind_e k, input logic [MODE_W-1:0] m,
                         input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] l,
                         input logic [TYPE_W-1:0] t, input status_e s,
                         input logic [ADDR_W-1:0] fr);
    dir_kind[dir_rows] = k;
    dir_mode[dir_rows] = m;
    dir_addr[dir_rows] = a;
    dir_len[dir_rows] = l;
    dir_type[dir_rows] = t;
    dir_status[dir_rows] = s;
    dir_frame[dir_rows] = fr;
    dir_rows++;
  endtask

  task automatic random_op();
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] addr, len;
    logic [TYPE_W-1:0] rtype;
    longint unsigned limit;
    int pick, base_f, span, idx;
    limit = (cfg_nframes > FRAMES) ? FRAMES : cfg_nframes;
    addr = ADDR_W'({$urandom, $urandom});
    len = ADDR_W'({$urandom, $urandom});
    rtype = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      mode = MODE_ALLOC;
    end else if (pick < 52) begin
      mode = MODE_FREE;
      if (held_frames.size() > 0) begin
        idx = $urandom_range(0, held_frames.size() - 1);
        addr = held_frames[idx];
        held_frames.delete(idx);
      end else begin
        addr = ADDR_W'(longint'($urandom_range(0, int'(limit) + 2)) << PAGE_SHIFT);
      end
    end else if (pick < 75) begin
      mode = MODE_REGION;
      rtype = REGION_USABLE;
      base_f = $urandom_range(0, int'(limit) + 3);
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, int'(limit) + 2)
                                         : $urandom_range(0, 40);
      addr = ADDR_W'(longint'(base_f) << PAGE_SHIFT);
      len = ADDR_W'(longint'(span) << PAGE_SHIFT);
      if ($urandom_range(0, 3) == 0) begin
        addr = addr + $urandom_range(0, PAGE_ROUND);
        len = len + $urandom_range(0, PAGE_ROUND);
      end
    end else if (pick < 84) begin
      mode = MODE_FREE;
      case ($urandom_range(0, 3))
        0: addr = '0;
        1: addr = ADDR_W'(longint'($urandom_range(0, int'(limit) + 2)) << PAGE_SHIFT);
        2: addr = ADDR_W'(longint'($urandom_range(0, int'(limit) + 2)) << PAGE_SHIFT)
                  + $urandom_range(1, PAGE_ROUND);
        default: ;
      endcase
    end else if (pick < 93) begin
      mode = MODE_REGION;
      if ($urandom_range(0, 2) == 0) rtype = REGION_USABLE;
    end else begin
      mode = MODE_NONE;
    end
    send_op(mode, addr, len, rtype, 1'b0, STATUS_OK, '0);
  endtask

  task automatic random_phase(input int n_items, input logic [CFG_W-1:0] fc,
                              input logic [CFG_W-1:0] first);
    bit calm;
    int i;
    write_config(fc, first);
    calm = ($urandom_range(0, 3) == 0);
    for (i = 0; i < n_items; i++) begin
      random_op();
      idle_gap(calm);
    end
  endtask

  initial begin
    int i;
    logic [CFG_W-1:0] fc;
    logic [CFG_W-1:0] first;
    errors = 0;
    dir_rows = 0;
    cfg_nframes = '0;
    cfg_first_alloc = '0;
    rst_ni = 1'b0;
    start = 1'b0;
    mode_i = '0;
    address_i = '0;
    region_length_i = '0;
    region_type_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    // nothing managed yet
    add_row(ROW_TYPED, MODE_ALLOC, '0, '0, '0, STATUS_NO_FRAME, '0);
    add_row(ROW_TYPED, MODE_FREE, '0, '0, '0, STATUS_OK, '0);
    add_row(ROW_TYPED, MODE_FREE, 48'h1000, '0, '0, STATUS_BAD_FREE, '0);
    add_row(ROW_TYPED, MODE_NONE, '1, '1, '1, STATUS_OK, '0);
    add_row(ROW_TYPED, MODE_REGION, '0, '1, REGION_USABLE, STATUS_OK, '0);
    add_row(ROW_CFG, MODE_NONE, 48'd64, 48'd2, '0, STATUS_OK, '0);
    add_row(ROW_TYPED, MODE_REGION, '0, 48'h40000, REGION_USABLE, STATUS_OK, '0);
    add_row(ROW_TYPED, MODE_ALLOC, '0, '0, '0, STATUS_OK, 48'h2000);
    add_row(ROW_TYPED, MODE_ALLOC, '0, '0, '0, STATUS_OK, 48'h3000);
    add_row(ROW_TYPED, MODE_FREE, 48'h2000, '0, '0, STATUS_OK, '0);
    add_row(ROW_TYPED, MODE_FREE, 48'h2000, '0, '0, STATUS_BAD_FREE, '0);
    add_row(ROW_TYPED, MODE_FREE, 48'h2001, '0, '0, STATUS_BAD_FREE, '0);
    // below first_alloc_frame, still used: accepted
    add_row(ROW_TYPED, MODE_FREE, 48'h1000, '0, '0, STATUS_OK, '0);
    add_row(ROW_TYPED, MODE_ALLOC, '0, '0, '0, STATUS_OK, 48'h2000);
    add_row(ROW_TYPED, MODE_FREE, 48'h40000, '0, '0, STATUS_BAD_FREE, '0);
    add_row(ROW_TYPED, MODE_FREE, 48'hFFFF_FFFF_F000, '0, '0, STATUS_BAD_FREE, '0);
    add_row(ROW_TYPED, MODE_FREE, '1, '0, '0, STATUS_BAD_FREE, '0);
    add_row(ROW_TYPED, MODE_REGION, '0, '1, '0, STATUS_OK, '0);
    add_row(ROW_TYPED, MODE_REGION, '0, '1, '1, STATUS_OK, '0);
    add_row(ROW_TYPED, MODE_REGION, '1, '1, REGION_USABLE, STATUS_OK, '0);
    add_row(ROW_TYPED, MODE_REGION, 48'h1001, 48'h1FFF, REGION_USABLE, STATUS_OK, '0);
    add_row(ROW_TYPED, MODE_REGION, 48'h5000, '0, REGION_USABLE, STATUS_OK, '0);
    add_row(ROW_MODEL, MODE_ALLOC, '0, '0, '0, STATUS_OK, '0);
    // oversized frame count clamps to the bitmap size
    add_row(ROW_CFG, MODE_NONE, 48'h1FFFF, 48'd65535, '0, STATUS_OK, '0);
    add_row(ROW_TYPED, MODE_REGION, 48'hFFFF000, 48'h1000, REGION_USABLE, STATUS_OK, '0);
    add_row(ROW_TYPED, MODE_ALLOC, '0, '0, '0, STATUS_OK, 48'hFFFF000);
    add_row(ROW_TYPED, MODE_ALLOC, '0, '0, '0, STATUS_NO_FRAME, '0);
    add_row(ROW_TYPED, MODE_FREE, 48'h1000_0000, '0, '0, STATUS_BAD_FREE, '0);
    add_row(ROW_CFG, MODE_NONE, 48'd65536, 48'd0, '0, STATUS_OK, '0);
    add_row(ROW_MODEL, MODE_ALLOC, '0, '0, '0, STATUS_OK, '0);
    add_row(ROW_TYPED, MODE_FREE, 48'hFFFF000, '0, '0, STATUS_OK, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < dir_rows; i++) begin
      if (dir_kind[i] == ROW_CFG) begin
        write_config(dir_addr[i][CFG_W-1:0], dir_len[i][CFG_W-1:0]);
      end else begin
        send_op(dir_mode[i], dir_addr[i], dir_len[i], dir_type[i], dir_kind[i] == ROW_TYPED,
                dir_status[i], dir_frame[i]);
        idle_gap(1'b0);
      end
    end

    random_phase(70, 17'd64, 17'd0);
    random_phase(70, 17'h1FFFF, 17'd0);
    random_phase(40, 17'd0, 17'h1FFFF);
    fc = CFG_W'($urandom_range(1, 600));
    first = CFG_W'($urandom_range(0, fc));
    random_phase(70, fc, first);
    random_phase(60, 17'd65536, 17'd65535);
    fc = CFG_W'($urandom_range(1, 300));
    first = CFG_W'($urandom_range(0, fc + 20));
    random_phase(70, fc, first);
    fc = CFG_W'($urandom_range(0, 17'h1FFFF));
    first = CFG_W'($urandom_range(0, fc));
    random_phase(70, fc, first);
    fc = CFG_W'($urandom_range(1, 200));
    first = CFG_W'($urandom_range(0, 8));
    random_phase(90, fc, first);

    @(posedge clk_i);
    start <= 1'b0;
    wait_idle();
    repeat (1100) @(posedge clk_i);
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
